// ----- hdl/amc_pkg.sv -----
// Package for the accumulator machine core: sizes, opcodes, status codes,
// sequencer states and the shared ALU command type. No dependencies.
package amc_pkg;
  localparam int MemWords  = 4096;
  localparam int AddrW     = $clog2(MemWords);
  localparam int PcW       = AddrW + 1;
  localparam int StepW     = 40;
  localparam logic [StepW-1:0] StepLimitReset = 40'd10000000;

  localparam logic [31:0] OpAdd = 32'd1, OpSub = 32'd2, OpMul = 32'd3, OpDiv = 32'd4;
  localparam logic [31:0] OpJmp = 32'd5, OpJmpn = 32'd6, OpJmpp = 32'd7, OpJmpz = 32'd8;
  localparam logic [31:0] OpCopy = 32'd9, OpLoad = 32'd10, OpStore = 32'd11;
  localparam logic [31:0] OpInput = 32'd12, OpOutput = 32'd13, OpStop = 32'd14;

  localparam logic [2:0] StOk = 3'd0, StHalt = 3'd1, StAddr = 3'd2;
  localparam logic [2:0] StDivZero = 3'd3, StBadOp = 3'd4, StLimit = 3'd5;

  localparam logic [1:0] FnLoad = 2'd0, FnExec = 2'd1, FnRestart = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_FOP, S_DOP, S_DA, S_DB, S_DDATA, S_ALU, S_WAIT, S_WB, S_OUT
  } state_e;

  typedef enum logic [1:0] { ALU_MUL, ALU_DIV } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_cmd_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] result;
  } alu_sts_t;
endpackage

// ----- hdl/amc_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module amc_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// ----- hdl/amc_alu.sv -----
// Shared iterative multiply/divide unit, one bit per cycle.
// Depends on amc_pkg.
module amc_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  amc_pkg::alu_cmd_t cmd_i,
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  output amc_pkg::alu_sts_t sts_o
);
  import amc_pkg::*;

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  alu_op_e     op_q, op_d;
  logic [31:0] acc_q, acc_d, x_q, x_d, y_q, y_d;
  logic [32:0] rem_sh;
  logic [31:0] na, nb;

  always_comb begin
    na = a_i[31] ? 32'(0 - a_i) : a_i;
    nb = b_i[31] ? 32'(0 - b_i) : b_i;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0; neg_d = neg_q; op_d = op_q;
    acc_d = acc_q; x_d = x_q; y_d = y_q;
    rem_sh = {acc_q, x_q[31]};
    if (cmd_i.start) begin
      busy_d = 1'b1; cnt_d = 6'd0; op_d = cmd_i.op; acc_d = '0;
      if (cmd_i.op == ALU_MUL) begin
        x_d = a_i; y_d = b_i; neg_d = 1'b0;
      end else begin
        x_d = na; y_d = nb; neg_d = a_i[31] ^ b_i[31];
      end
    end else if (busy_q) begin
      if (op_q == ALU_MUL) begin
        if (y_q[0]) acc_d = acc_q + x_q;
        x_d = x_q << 1; y_d = y_q >> 1;
      end else begin
        x_d = {x_q[30:0], 1'b0};
        if (rem_sh >= {1'b0, y_q}) begin
          acc_d = 32'(rem_sh - {1'b0, y_q}); x_d[0] = 1'b1;
        end else begin
          acc_d = rem_sh[31:0];
        end
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; busy_q <= 1'b0; done_q <= 1'b0; neg_q <= 1'b0; op_q <= ALU_MUL;
    end else begin
      cnt_q <= cnt_d; busy_q <= busy_d; done_q <= done_d; neg_q <= neg_d; op_q <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; x_q <= x_d; y_q <= y_d;
  end

  always_comb begin
    sts_o.busy = busy_q;
    sts_o.done = done_q;
    if (op_q == ALU_MUL) sts_o.result = acc_q;
    else sts_o.result = neg_q ? 32'(0 - x_q) : x_q;
  end

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.done |-> $past(busy_q)) else $error("alu done without busy");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !busy_q) else $error("alu start while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.done |=> !sts_o.done) else $error("alu done held");
endmodule

// ----- hdl/accumulator_machine_core_unit.sv -----
// Accumulator machine core: sequencer, word memory and shared mul/div unit.
// Depends on amc_pkg, amc_ram and amc_alu.
//
// One beat in gives one beat out. After reset the memory is cleared one word
// a cycle (MemWords = 4096 words) before the first beat is taken. A load,
// restart or unknown func goes straight from accept to result, as does an
// instruction that stops on the step limit or on the PC check. A bad opcode,
// STOP or operand overrun ends after the opcode read, a bad operand address
// after that operand's read. Else the single memory port reads opcode,
// operands and data, then writes back for STORE, INPUT and COPY; MUL, and DIV
// by a nonzero word, wait on the bit-serial unit. The result waits in an
// output register and is held there while the receiver stalls.
module accumulator_machine_core_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // from bit 0: func[1:0], load_address[11:0], load_value[31:0], input_value[31:0], 2 pad bits
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // from bit 0: status, out_valid, out_value, input_taken, pc_now, acc_now, 7 pad bits
  output logic [87:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [39:0] cfg_data
);
  import amc_pkg::*;

  state_e           st_q, st_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [StepW-1:0] limit_q, steps_q, steps_d;
  logic [31:0]      acc_q, acc_d, op_q, op_d, a_q, a_d, b_q, b_d, in_q, in_d;
  logic [PcW-1:0]   pc_q, pc_d;
  logic [2:0]       stop_q, stop_d;
  logic             ovalid_q, ovalid_d, itk_q, itk_d;
  logic [31:0]      oval_q, oval_d;
  logic [1:0]       fn;
  logic             we;
  logic [AddrW-1:0] addr;
  logic [31:0]      wdata, rdata;
  alu_cmd_t         cmd;
  alu_sts_t         sts;
  logic [PcW:0]     pc_end;

  assign fn = s_axis_tdata[1:0];

  amc_ram #(.Width(32), .Depth(MemWords)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  amc_alu u_alu (.clk_i, .rst_ni, .cmd_i(cmd), .a_i(acc_q), .b_i(rdata), .sts_o(sts));

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = (st_q == S_OUT);
  assign m_axis_tdata = {7'b0, acc_q, pc_q[AddrW-1:0], itk_q, oval_q, ovalid_q, stop_q};

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_CLEAR: if (clr_q == AddrW'(MemWords - 1)) st_d = S_IDLE;
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (fn == FnExec && stop_q == StOk && steps_q <= limit_q && pc_q < PcW'(MemWords))
            st_d = S_FOP;
          else st_d = S_OUT;
        end
      end
      S_FOP: st_d = S_DOP;
      S_DOP: begin
        if (rdata < OpAdd || rdata > OpStop || rdata == OpStop) st_d = S_OUT;
        else if (pc_end > (PcW+1)'(MemWords)) st_d = S_OUT;
        else st_d = S_DA;
      end
      S_DA: begin
        if (rdata >= 32'(MemWords)) st_d = S_OUT;
        else if (op_q == OpCopy) st_d = S_DB;
        else st_d = S_DDATA;
      end
      S_DB: st_d = (rdata >= 32'(MemWords)) ? S_OUT : S_DDATA;
      S_DDATA: st_d = S_ALU;
      S_ALU: begin
        if (op_q == OpMul || (op_q == OpDiv && rdata != '0)) st_d = S_WAIT;
        else if (op_q == OpCopy || op_q == OpStore || op_q == OpInput) st_d = S_WB;
        else st_d = S_OUT;
      end
      S_WAIT: if (sts.done) st_d = S_OUT;
      S_WB: st_d = S_OUT;
      S_OUT: if (m_axis_tready) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    steps_d = steps_q; acc_d = acc_q; pc_d = pc_q; stop_d = stop_q;
    op_d = op_q; a_d = a_q; b_d = b_q; in_d = in_q;
    ovalid_d = ovalid_q; itk_d = itk_q; oval_d = oval_q;
    clr_d = clr_q; we = 1'b0; addr = '0; wdata = '0;
    cmd.start = 1'b0; cmd.op = (op_q == OpMul) ? ALU_MUL : ALU_DIV;
    pc_end = {1'b0, pc_q} + ((op_q == OpCopy) ? (PcW+1)'(3) : (PcW+1)'(2));
    case (st_q)
      S_CLEAR: begin
        we = 1'b1; addr = clr_q; clr_d = clr_q + AddrW'(1);
      end
      S_IDLE: begin
        addr = pc_q[AddrW-1:0];
        if (s_axis_tvalid) begin
          ovalid_d = 1'b0; itk_d = 1'b0; oval_d = '0;
          in_d = s_axis_tdata[77:46];
          case (fn)
            FnLoad: begin
              we = 1'b1; addr = s_axis_tdata[2 +: AddrW]; wdata = s_axis_tdata[45:14];
            end
            FnRestart: begin
              acc_d = '0; pc_d = '0; steps_d = '0; stop_d = StOk;
            end
            FnExec: begin
              if (stop_q == StOk) begin
                if (steps_q > limit_q) stop_d = StLimit;
                else begin
                  steps_d = steps_q + StepW'(1);
                  if (pc_q >= PcW'(MemWords)) stop_d = StAddr;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_FOP: addr = pc_q[AddrW-1:0];
      S_DOP: begin
        op_d = rdata;
        addr = AddrW'(pc_q + PcW'(1));
        if (rdata < OpAdd || rdata > OpStop) stop_d = StBadOp;
        else if (rdata == OpStop) stop_d = StHalt;
        else begin
          pc_end = {1'b0, pc_q} + ((rdata == OpCopy) ? (PcW+1)'(3) : (PcW+1)'(2));
          if (pc_end > (PcW+1)'(MemWords)) stop_d = StAddr;
        end
      end
      S_DA: begin
        a_d = rdata;
        addr = AddrW'(pc_q + PcW'(2));
        if (rdata >= 32'(MemWords)) stop_d = StAddr;
        else if (op_q != OpCopy) addr = rdata[AddrW-1:0];
      end
      S_DB: begin
        b_d = rdata; addr = a_q[AddrW-1:0];
        if (rdata >= 32'(MemWords)) stop_d = StAddr;
      end
      S_DDATA: addr = a_q[AddrW-1:0];
      S_ALU: begin
        b_d = rdata;
        pc_d = pc_end[PcW-1:0];
        case (op_q)
          OpAdd:  acc_d = acc_q + rdata;
          OpSub:  acc_d = acc_q - rdata;
          OpMul:  cmd.start = 1'b1;
          OpDiv: begin
            if (rdata == '0) begin
              stop_d = StDivZero; pc_d = pc_q;
            end else cmd.start = 1'b1;
          end
          OpJmp:  pc_d = a_q[PcW-1:0];
          OpJmpn: if (acc_q[31]) pc_d = a_q[PcW-1:0];
          OpJmpp: if (!acc_q[31] && acc_q != '0) pc_d = a_q[PcW-1:0];
          OpJmpz: if (acc_q == '0) pc_d = a_q[PcW-1:0];
          OpLoad: acc_d = rdata;
          OpOutput: begin
            ovalid_d = 1'b1; oval_d = rdata;
          end
          default: ;
        endcase
      end
      S_WAIT: if (sts.done) acc_d = sts.result;
      S_WB: begin
        we = 1'b1;
        case (op_q)
          OpCopy: begin
            addr = b_q[AddrW-1:0]; wdata = b_q;
            wdata = oval_q;
          end
          OpStore: begin
            addr = a_q[AddrW-1:0]; wdata = acc_q;
          end
          default: begin
            addr = a_q[AddrW-1:0]; wdata = in_q; itk_d = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
    // COPY source word parks in oval_q until writeback; cleared afterwards
    if (st_q == S_ALU && op_q == OpCopy) begin
      oval_d = rdata; b_d = b_q;
    end
    if (st_q == S_WB) oval_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR; clr_q <= '0; limit_q <= StepLimitReset; steps_q <= '0;
      acc_q <= '0; pc_q <= '0; stop_q <= StOk;
      ovalid_q <= 1'b0; itk_q <= 1'b0; oval_q <= '0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; steps_q <= steps_d;
      acc_q <= acc_d; pc_q <= pc_d; stop_q <= stop_d;
      ovalid_q <= ovalid_d; itk_q <= itk_d; oval_q <= oval_d;
      if (cfg_valid) limit_q <= cfg_data;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; a_q <= a_d; b_q <= b_d; in_q <= in_d;
  end

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
  a_wait_alu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_WAIT) |-> (sts.busy || sts.done)) else $error("waiting on idle alu");
  a_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !ovalid_q) |-> (oval_q == '0)) else $error("stale out_value");
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for accumulator_machine_core_unit, needs amc_pkg: directed
// table then random programs loaded and stepped, checked vs predictor or typed rows.
module tb_top;
  import amc_pkg::*;

  localparam logic [1:0] FnNone = 2'd3;

  typedef struct packed {
    logic [31:0] acc_now;
    logic [11:0] pc_now;
    logic        input_taken;
    logic [31:0] out_value;
    logic        out_valid;
    logic [2:0]  status;
  } mach_res_t;

  typedef struct {
    logic [1:0]  fn;
    logic [11:0] addr;
    logic [31:0] lval;
    logic [31:0] ival;
    bit          typed;
    logic [2:0]  st;
    logic [11:0] pc;
    logic [31:0] acc;
  } dir_row_t;

  logic        clk_i = 0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [87:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [39:0] cfg_data;

  accumulator_machine_core_unit u_top (.*);

  always #4 clk_i = ~clk_i;

  // machine image
  logic [31:0]      mem_img [MemWords];
  logic [31:0]      acc_img;
  logic [12:0]      pc_img;
  logic [StepW-1:0] steps_img;
  logic [2:0]       stop_img;
  logic [StepW-1:0] limit_img;

  mach_res_t exp_q[$];
  int n_items, n_results, n_errors, n_halts, snd_idle, rcv_stall;

  function automatic logic [31:0] div_toward_zero(logic [31:0] n, logic [31:0] d);
    logic [31:0] nm, dm, q;
    nm = n[31] ? -n : n;
    dm = d[31] ? -d : d;
    q = nm / dm;
    return (n[31] ^ d[31]) ? -q : q;
  endfunction

  function automatic void run_instr(logic [31:0] ival, ref mach_res_t r);
    logic [31:0] op, a, b, w;
    logic [12:0] pc, sz;
    pc = pc_img;
    if (steps_img > limit_img) begin stop_img = StLimit; return; end
    steps_img = steps_img + 1;
    if (pc >= MemWords) begin stop_img = StAddr; return; end
    op = mem_img[pc];
    if (op < OpAdd || op > OpStop) begin stop_img = StBadOp; return; end
    if (op == OpStop) begin stop_img = StHalt; return; end
    sz = (op == OpCopy) ? 13'd3 : 13'd2;
    if (pc + sz > MemWords) begin stop_img = StAddr; return; end
    a = mem_img[pc + 1];
    if (a >= MemWords) begin stop_img = StAddr; return; end
    if (op == OpCopy) begin
      b = mem_img[pc + 2];
      if (b >= MemWords) begin stop_img = StAddr; return; end
    end
    w = mem_img[a];
    case (op)
      OpAdd: acc_img = acc_img + w;
      OpSub: acc_img = acc_img - w;
      OpMul: acc_img = acc_img * w;
      OpDiv: begin
        if (w == 0) begin stop_img = StDivZero; return; end
        acc_img = div_toward_zero(acc_img, w);
      end
      OpJmp: begin pc_img = a[12:0]; return; end
      OpJmpn: begin pc_img = acc_img[31] ? a[12:0] : pc + 13'd2; return; end
      OpJmpp: begin
        pc_img = (!acc_img[31] && acc_img != 0) ? a[12:0] : pc + 13'd2;
        return;
      end
      OpJmpz: begin pc_img = (acc_img == 0) ? a[12:0] : pc + 13'd2; return; end
      OpCopy: mem_img[b] = w;
      OpLoad: acc_img = w;
      OpStore: mem_img[a] = acc_img;
      OpInput: begin mem_img[a] = ival; r.input_taken = 1; end
      default: begin r.out_valid = 1; r.out_value = w; end
    endcase
    pc_img = pc + sz;
  endfunction

  function automatic mach_res_t predict_machine(logic [1:0] fn, logic [11:0] addr,
                                                logic [31:0] lval, logic [31:0] ival);
    mach_res_t r;
    r = '0;
    case (fn)
      FnLoad: mem_img[addr] = lval;
      FnExec: if (stop_img == StOk) run_instr(ival, r);
      FnRestart: begin acc_img = 0; pc_img = 0; steps_img = 0; stop_img = StOk; end
      default: ;
    endcase
    r.status = stop_img;
    r.pc_now = pc_img[11:0];
    r.acc_now = acc_img;
    return r;
  endfunction

  // one beat on the slave side; typed rows override the predicted value
  task automatic send_item(logic [1:0] fn, logic [11:0] addr, logic [31:0] lval,
                           logic [31:0] ival, bit typed = 0, mach_res_t tv = '0);
    mach_res_t r;
    if ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {2'b0, ival, lval, addr, fn};
    r = predict_machine(fn, addr, lval, ival);
    exp_q.push_back(typed ? tv : r);
    n_items++;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [StepW-1:0] v);
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 0;
    limit_img = v;
  endtask

  function automatic logic [31:0] rand_data_addr();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(0, MemWords - 1);
      default: return 2048 + $urandom_range(0, 15);
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(1, 20);
      default: return $urandom();
    endcase
  endfunction

  // load a short random program plus data, restart, then step it
  task automatic run_program();
    int base, p, n, tgt;
    logic [31:0] op;
    base = ($urandom_range(4) == 0) ? 4080 + $urandom_range(0, 15)
         : ($urandom_range(1) ? 0 : $urandom_range(16, 40));
    n = $urandom_range(3, 10);
    p = base;
    for (int i = 0; i < n && p < MemWords; i++) begin
      if ($urandom_range(15) == 0) op = $urandom();
      else if (i == n - 1 && $urandom_range(1)) op = OpStop;
      else op = $urandom_range(OpAdd, OpOutput);
      send_item(FnLoad, 12'(p), op, $urandom());
      p++;
      if (op >= OpJmp && op <= OpJmpz) begin
        tgt = base + 2 * $urandom_range(0, n);
        if (p < MemWords) send_item(FnLoad, 12'(p),
                                    ($urandom_range(9) == 0) ? $urandom() : 32'(tgt),
                                    $urandom());
        p++;
      end else if (op != OpStop && op >= OpAdd && op <= OpOutput) begin
        if (p < MemWords) send_item(FnLoad, 12'(p), rand_data_addr(), $urandom());
        p++;
        if (op == OpCopy) begin
          if (p < MemWords) send_item(FnLoad, 12'(p), rand_data_addr(), $urandom());
          p++;
        end
      end
    end
    repeat ($urandom_range(1, 4)) send_item(FnLoad, 12'(2048 + $urandom_range(0, 15)),
                                            rand_word(), $urandom());
    if (base != 0) begin
      send_item(FnLoad, 12'd0, OpJmp, $urandom());
      send_item(FnLoad, 12'd1, 32'(base), $urandom());
    end
    send_item(FnRestart, 12'($urandom()), $urandom(), $urandom());
    repeat ($urandom_range(5, 25)) send_item(FnExec, 12'($urandom()), $urandom(), rand_word());
    if ($urandom_range(7) == 0)
      send_item(2'($urandom_range(0, 3)), 12'($urandom()), $urandom(), $urandom());
  endtask

  // master side: random stall, compare every beat with the oldest expectation
  always @(posedge clk_i) begin
    mach_res_t got, want;
    m_axis_tready <= ($urandom_range(99) >= rcv_stall);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[80:0];
      n_results++;
      if (exp_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected beat %h", got);
      end else begin
        want = exp_q.pop_front();
        if (got.status inside {StHalt, StAddr, StDivZero, StBadOp, StLimit}) n_halts++;
        if (got.status !== want.status || got.out_valid !== want.out_valid ||
            got.out_value !== want.out_value || got.input_taken !== want.input_taken ||
            got.pc_now !== want.pc_now || got.acc_now !== want.acc_now) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("beat %0d: exp st=%0d ov=%b val=%h it=%b pc=%h acc=%h", n_results,
                     want.status, want.out_valid, want.out_value, want.input_taken,
                     want.pc_now, want.acc_now);
            $display("        got st=%0d ov=%b val=%h it=%b pc=%h acc=%h",
                     got.status, got.out_valid, got.out_value, got.input_taken,
                     got.pc_now, got.acc_now);
          end
        end
      end
    end
  end

  initial begin
    #8ms;
    $display("timeout with %0d results outstanding", exp_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    dir_row_t dir_tab[$];
    logic [StepW-1:0] phase_limit[4];
    mach_res_t tv;
    dir_tab = '{
      '{FnExec,    0, 0, 0, 1, StBadOp, 0, 0},
      '{FnRestart, 0, 0, 0, 1, StOk, 0, 0},
      '{FnLoad,    0, OpStop, 0, 1, StOk, 0, 0},
      '{FnExec,    0, 0, 0, 1, StHalt, 0, 0},
      '{FnExec,    0, 0, 0, 1, StHalt, 0, 0},
      '{FnRestart, 0, 0, 0, 1, StOk, 0, 0},
      '{FnLoad,    0, OpLoad, 0, 0, 0, 0, 0},
      '{FnLoad,    1, 100, 0, 0, 0, 0, 0},
      '{FnLoad,  100, 32'h8000_0000, 0, 0, 0, 0, 0},
      '{FnLoad,    2, OpDiv, 0, 0, 0, 0, 0},
      '{FnLoad,    3, 101, 0, 0, 0, 0, 0},
      '{FnLoad,  101, 32'hFFFF_FFFF, 0, 0, 0, 0, 0},
      '{FnLoad,    4, OpInput, 0, 0, 0, 0, 0},
      '{FnLoad,    5, 102, 0, 0, 0, 0, 0},
      '{FnLoad,    6, OpOutput, 0, 0, 0, 0, 0},
      '{FnLoad,    7, 102, 0, 0, 0, 0, 0},
      '{FnLoad,    8, OpDiv, 0, 0, 0, 0, 0},
      '{FnLoad,    9, 103, 0, 0, 0, 0, 0},
      '{FnExec,    0, 0, 0, 1, StOk, 2, 32'h8000_0000},
      '{FnExec,    0, 0, 0, 1, StOk, 4, 32'h8000_0000},
      '{FnExec,    0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0},
      '{FnExec,    0, 0, 0, 0, 0, 0, 0},
      '{FnExec,    0, 0, 0, 1, StDivZero, 8, 32'h8000_0000},
      '{FnNone, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0},
      '{FnLoad, 12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0}
    };
    foreach (mem_img[i]) mem_img[i] = 0;
    acc_img = 0; pc_img = 0; steps_img = 0; stop_img = StOk; limit_img = StepLimitReset;
    n_items = 0; n_results = 0; n_errors = 0; n_halts = 0;
    snd_idle = 0; rcv_stall = 0;
    rst_ni <= 0;
    s_axis_tvalid <= 0;
    s_axis_tdata <= '0;
    cfg_valid <= 0;
    cfg_data <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      tv = '0;
      tv.status = dir_tab[i].st;
      tv.pc_now = dir_tab[i].pc;
      tv.acc_now = dir_tab[i].acc;
      send_item(dir_tab[i].fn, dir_tab[i].addr, dir_tab[i].lval, dir_tab[i].ival,
                dir_tab[i].typed, tv);
    end

    phase_limit = '{40'hFF_FFFF_FFFF, 40'd1, 40'($urandom_range(5, 40)), StepLimitReset};
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(phase_limit[ph]);
      case (ph)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 65; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 65; end
        default: begin snd_idle = 12; rcv_stall = 12; end
      endcase
      while (n_items < 25 + (ph + 1) * 460) run_program();
    end
    s_axis_tvalid <= 0;

    @(posedge clk_i);
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("%0d beats sent, %0d results checked, %0d stop states seen, four step limits",
             n_items, n_results, n_halts);
    if (n_errors == 0 && exp_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
